### rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, character constants and the alphabet map of the base64
// stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
	localparam logic [7:0] CHAR_PLUS    = 8'h2B;
	localparam logic [7:0] CHAR_SLASH   = 8'h2F;
	localparam logic [7:0] CHAR_PAD     = 8'h3D;

	// Offsets that bring each character range onto its six-bit value.
	localparam logic [7:0] LOWER_OFFSET = 8'd71;
	localparam logic [7:0] DIGIT_OFFSET = 8'd4;
	localparam logic [5:0] SEXTET_PLUS  = 6'd62;
	localparam logic [5:0] SEXTET_SLASH = 6'd63;

	localparam int unsigned MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_data;
		logic       bad_char;
		logic       frame_end;
	} result_t;

	// Results caused by one request, in order, and how many of them are used.
	typedef struct packed {
		logic [1:0]                    count;
		result_t [MAX_RESULTS-1:0]     res;
	} burst_t;

	typedef struct packed {
		logic       valid;
		logic [5:0] value;
	} sextet_t;

	function automatic sextet_t sextet_of(input logic [7:0] c);
		sextet_t s;
		s = '0;
		priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			s = '{valid: 1'b1, value: 6'(c - CHAR_UPPER_A)};
		end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			s = '{valid: 1'b1, value: 6'(c - LOWER_OFFSET)};
		end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
			s = '{valid: 1'b1, value: 6'(c + DIGIT_OFFSET)};
		end else if (c == CHAR_PLUS) begin
			s = '{valid: 1'b1, value: SEXTET_PLUS};
		end else if (c == CHAR_SLASH) begin
			s = '{valid: 1'b1, value: SEXTET_SLASH};
		end else begin
			s = '0;
		end
		return s;
	endfunction

endpackage

### rtl/b64d_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_if
// Valid/ready channels of the base64 decoder: characters in, bytes out.
// ----------------------------------------------------------------------------
interface b64d_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       frame_last;

	modport source (output valid, output char_code, output frame_last, input ready);
	modport sink   (input valid, input char_code, input frame_last, output ready);
endinterface

interface b64d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_data;
	logic       bad_char;
	logic       frame_end;
	logic       run_last;

	modport source (output valid, output data_byte, output has_data, output bad_char,
		output frame_end, output run_last, input ready);
	modport sink   (input valid, input data_byte, input has_data, input bad_char,
		input frame_end, input run_last, output ready);
endinterface

### rtl/b64d_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_decode
// Holds the group state and turns one character into its burst of results.
// ----------------------------------------------------------------------------
module b64d_decode
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] char_code,
	input  logic       frame_last,
	output burst_t     burst
);

	logic [1:0]  group_count_q;
	logic [17:0] held_sextets_q;
	logic        pad_seen_q;
	logic        discarding_q;

	logic [1:0]  group_count_d;
	logic [17:0] held_sextets_d;
	logic        pad_seen_d;
	logic        discarding_d;
	logic        new_bad;
	logic [23:0] word;
	sextet_t     sx;

	always_comb begin
		sx             = sextet_of(char_code);
		word           = {held_sextets_q, sx.value};
		group_count_d  = group_count_q;
		held_sextets_d = held_sextets_q;
		pad_seen_d     = pad_seen_q;
		discarding_d   = discarding_q;
		new_bad        = 1'b0;
		burst          = '0;

		if (!discarding_q && !pad_seen_q) begin
			priority if (char_code == CHAR_PAD) begin
				pad_seen_d = 1'b1;
			end else if (!sx.valid) begin
				discarding_d              = 1'b1;
				new_bad                   = 1'b1;
				burst.count               = 2'd1;
				burst.res[0].bad_char     = 1'b1;
				burst.res[0].frame_end    = frame_last;
			end else if (group_count_q == 2'd3) begin
				burst.count               = 2'd3;
				burst.res[0]              = '{data_byte: word[23:16], has_data: 1'b1,
					bad_char: 1'b0, frame_end: 1'b0};
				burst.res[1]              = '{data_byte: word[15:8], has_data: 1'b1,
					bad_char: 1'b0, frame_end: 1'b0};
				burst.res[2]              = '{data_byte: word[7:0], has_data: 1'b1,
					bad_char: 1'b0, frame_end: 1'b0};
				group_count_d             = 2'd0;
				held_sextets_d            = '0;
			end else begin
				held_sextets_d = word[17:0];
				group_count_d  = group_count_q + 2'd1;
			end
		end

		// Frame end flushes the partial group. Only the three-byte case and the
		// new-error case can already have results here.
		if (frame_last) begin
			priority if (new_bad) begin
				burst.count = 2'd1;
			end else if (discarding_d) begin
				burst.count  = 2'd1;
				burst.res[0] = '{data_byte: 8'h00, has_data: 1'b0,
					bad_char: 1'b1, frame_end: 1'b1};
			end else if (group_count_d == 2'd2) begin
				burst.count  = 2'd1;
				burst.res[0] = '{data_byte: held_sextets_d[11:4], has_data: 1'b1,
					bad_char: 1'b0, frame_end: 1'b1};
			end else if (group_count_d == 2'd3) begin
				burst.count  = 2'd2;
				burst.res[0] = '{data_byte: held_sextets_d[17:10], has_data: 1'b1,
					bad_char: 1'b0, frame_end: 1'b0};
				burst.res[1] = '{data_byte: held_sextets_d[9:2], has_data: 1'b1,
					bad_char: 1'b0, frame_end: 1'b1};
			end else if (burst.count == 2'd3) begin
				burst.res[2].frame_end = 1'b1;
			end else begin
				burst.count  = 2'd1;
				burst.res[0] = '{data_byte: 8'h00, has_data: 1'b0,
					bad_char: 1'b0, frame_end: 1'b1};
			end
			group_count_d  = 2'd0;
			held_sextets_d = '0;
			pad_seen_d     = 1'b0;
			discarding_d   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q  <= '0;
			held_sextets_q <= '0;
			pad_seen_q     <= 1'b0;
			discarding_q   <= 1'b0;
		end else if (accept) begin
			group_count_q  <= group_count_d;
			held_sextets_q <= held_sextets_d;
			pad_seen_q     <= pad_seen_d;
			discarding_q   <= discarding_d;
		end
	end

endmodule

### rtl/b64d_serialize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_serialize
// Result register that holds one burst and hands it out a result at a time.
// ----------------------------------------------------------------------------
module b64d_serialize
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       load,
	input  burst_t     burst,
	output logic       free,
	input  logic       out_ready,
	output logic       out_valid,
	output result_t    out_res,
	output logic       out_run_last
);

	logic       valid_q;
	logic [1:0] count_q;
	logic [1:0] idx_q;
	result_t [MAX_RESULTS-1:0] res_s2;
	logic       take;
	logic       last_take;

	assign out_valid    = valid_q;
	assign out_res      = res_s2[idx_q];
	assign out_run_last = (idx_q == count_q - 2'd1);
	assign take         = valid_q && out_ready;
	assign last_take    = take && out_run_last;
	// The register frees in the same cycle its final result is taken.
	assign free         = !valid_q || last_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= '0;
			idx_q   <= '0;
		end else if (load && burst.count != 2'd0) begin
			valid_q <= 1'b1;
			count_q <= burst.count;
			idx_q   <= '0;
		end else if (last_take) begin
			valid_q <= 1'b0;
		end else if (take) begin
			idx_q   <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_s2 <= burst.res;
		end
	end

endmodule

### rtl/base64_stream_decoder.sv
`timescale 1ns / 1ps
// The first result of a character is shown in the cycle after it is taken.
// One character per cycle while each yields at most one result, taken at once;
// a character yielding more holds the result register until its last is taken.
// Reset: arst_n clears the group state and empties the result register.
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Streaming base64 decoder, one character in, up to three results out.
// ----------------------------------------------------------------------------
module base64_stream_decoder
	import b64d_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	b64d_char_if.sink         text,
	b64d_byte_if.source       bytes
);

	logic    free;
	logic    accept;
	burst_t  burst;
	result_t out_res;

	assign text.ready = free;
	assign accept     = text.valid && free;

	b64d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.char_code  (text.char_code),
		.frame_last (text.frame_last),
		.burst      (burst)
	);

	b64d_serialize u_serialize (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.burst        (burst),
		.free         (free),
		.out_ready    (bytes.ready),
		.out_valid    (bytes.valid),
		.out_res      (out_res),
		.out_run_last (bytes.run_last)
	);

	assign bytes.data_byte = out_res.data_byte;
	assign bytes.has_data  = out_res.has_data;
	assign bytes.bad_char  = out_res.bad_char;
	assign bytes.frame_end = out_res.frame_end;

endmodule

### rtl/b64d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// Port-level checks of the base64 decoder, bound to the top level.
// ----------------------------------------------------------------------------
module b64d_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic in_last,
	input logic out_valid,
	input logic out_ready,
	input logic out_has_data,
	input logic out_bad_char,
	input logic out_run_last
);

	// A result that is not taken stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A stalled output never lets a new request in.
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("request accepted while the result register is stalled");

	// The last character of a frame always yields a result.
	a_last_yields: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> out_valid)
		else $error("frame end produced no result");

	a_bad_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_has_data && out_bad_char))
		else $error("error result carries a data byte");

	// An error result is always the only result of its request.
	a_bad_alone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_bad_char |-> out_run_last)
		else $error("error result followed by more results of the same request");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (text.valid),
	.in_ready     (text.ready),
	.in_last      (text.frame_last),
	.out_valid    (bytes.valid),
	.out_ready    (bytes.ready),
	.out_has_data (bytes.has_data),
	.out_bad_char (bytes.bad_char),
	.out_run_last (bytes.run_last)
);
